### hw/rtl/ita2e_pkg.sv
// Package for the ITA2 shift encoder.
// Holds the shift-class and shift-page types, ITA2 shift codes and the character table.
// No dependencies.
package ita2e_pkg;

    localparam int CHAR_W = 8;
    localparam int CODE_W = 5;

    localparam logic [CODE_W-1:0] CODE_FIGS = 5'd27;
    localparam logic [CODE_W-1:0] CODE_LTRS = 5'd31;

    typedef enum logic [1:0] {
        CLS_ANY = 2'b00,
        CLS_LTR = 2'b01,
        CLS_FIG = 2'b10
    } t_cls;

    typedef enum logic [1:0] {
        PAGE_UNK = 2'd0,
        PAGE_LTR = 2'd1,
        PAGE_FIG = 2'd2
    } t_page;

    typedef struct packed {
        logic              mapped;
        t_cls              cls;
        logic [CODE_W-1:0] code;
    } t_entry;

    function automatic logic [15:0] f_table(input logic [CHAR_W-1:0] ch);
        logic [15:0] v;
        unique case (ch)
            8'h0D: v = 16'h0002;
            8'h0A: v = 16'h0008;
            8'h20: v = 16'h0004;
            8'h07: v = 16'h8014;
            8'h21: v = 16'h8016;
            8'h22: v = 16'h8011;
            8'h23: v = 16'h8005;
            8'h24: v = 16'h8012;
            8'h26: v = 16'h800B;
            8'h27: v = 16'h801A;
            8'h28: v = 16'h801E;
            8'h29: v = 16'h8009;
            8'h2B: v = 16'h8011;
            8'h2C: v = 16'h8006;
            8'h2D: v = 16'h8018;
            8'h2E: v = 16'h8007;
            8'h2F: v = 16'h8017;
            8'h30: v = 16'h800D;
            8'h31: v = 16'h801D;
            8'h32: v = 16'h8019;
            8'h33: v = 16'h8010;
            8'h34: v = 16'h800A;
            8'h35: v = 16'h8001;
            8'h36: v = 16'h8015;
            8'h37: v = 16'h801C;
            8'h38: v = 16'h800C;
            8'h39: v = 16'h8003;
            8'h3A: v = 16'h800E;
            8'h3B: v = 16'h800F;
            8'h3D: v = 16'h800F;
            8'h3F: v = 16'h8013;
            8'hC4: v = 16'h8008;
            8'hC5: v = 16'h8016;
            8'hD6: v = 16'h8005;
            8'h41: v = 16'h4018;
            8'h42: v = 16'h4013;
            8'h43: v = 16'h400E;
            8'h44: v = 16'h4012;
            8'h45: v = 16'h4010;
            8'h46: v = 16'h4016;
            8'h47: v = 16'h400B;
            8'h48: v = 16'h4005;
            8'h49: v = 16'h400C;
            8'h4A: v = 16'h401A;
            8'h4B: v = 16'h401E;
            8'h4C: v = 16'h4009;
            8'h4D: v = 16'h4007;
            8'h4E: v = 16'h4006;
            8'h4F: v = 16'h4003;
            8'h50: v = 16'h400D;
            8'h51: v = 16'h401D;
            8'h52: v = 16'h400A;
            8'h53: v = 16'h4014;
            8'h54: v = 16'h4001;
            8'h55: v = 16'h401C;
            8'h56: v = 16'h400F;
            8'h57: v = 16'h4019;
            8'h58: v = 16'h4017;
            8'h59: v = 16'h4015;
            8'h5A: v = 16'h4011;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    function automatic t_entry f_lookup(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] uc;
        logic [15:0]       raw;
        t_entry            e;
        uc = ch;
        if (ch >= 8'h61 && ch <= 8'h7A) begin
            uc = ch - 8'd32;
        end
        raw      = f_table(uc);
        e.mapped = (raw != 16'h0000);
        e.cls    = t_cls'(raw[15:14]);
        e.code   = raw[CODE_W-1:0];
        return e;
    endfunction

endpackage

### hw/rtl/ita2e_ifs.sv
// Valid/ready channel interfaces for the ITA2 shift encoder.
// Character input channel and code output channel; depends on ita2e_pkg.
interface ita2e_char_if;
    logic                         valid;
    logic                         ready;
    logic [ita2e_pkg::CHAR_W-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface ita2e_code_if;
    logic                         valid;
    logic                         ready;
    logic [ita2e_pkg::CODE_W-1:0] ita2_code;
    logic                         last;

    modport source (output valid, output ita2_code, output last, input ready);
    modport sink   (input valid, input ita2_code, input last, output ready);
endinterface

### hw/rtl/ita2e_lookup.sv
// Input register and character table lookup of the ITA2 shift encoder.
// Depends on ita2e_pkg and ita2e_char_if.
module ita2e_lookup (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ita2e_char_if.sink          i_char,
    output logic                o_vld,
    input  logic                i_rdy,
    output ita2e_pkg::t_entry   o_entry
);
    import ita2e_pkg::*;

    logic              r_vld;
    logic [CHAR_W-1:0] r_char;
    logic              n_vld;

    assign i_char.ready = !r_vld || i_rdy;
    assign n_vld        = i_char.ready ? i_char.valid : r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_char <= i_char.char_in;
        end
    end

    assign o_vld   = r_vld;
    assign o_entry = f_lookup(r_char);

`ifndef SYNTHESIS
    a_hold_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !i_rdy |=> r_vld && $stable(r_char))
        else $error("lookup stage lost a stalled item");
    a_take_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_char.valid && i_char.ready |=> r_vld)
        else $error("accepted item not registered");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld |-> i_char.ready)
        else $error("empty lookup stage not ready");
`endif

endmodule

### hw/rtl/ita2e_shift.sv
// Shift tracking and result register of the ITA2 shift encoder.
// Emits a needed shift code ahead of the held character code; depends on ita2e_pkg, ita2e_code_if.
module ita2e_shift (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    output logic                o_rdy,
    input  ita2e_pkg::t_entry   i_entry,
    ita2e_code_if.source        o_code
);
    import ita2e_pkg::*;

    logic              r_out_vld;
    logic [CODE_W-1:0] r_out_code;
    logic              r_out_last;
    logic              r_pend_vld;
    logic [CODE_W-1:0] r_pend_code;
    t_page             r_page;

    logic              n_out_vld;
    logic [CODE_W-1:0] n_out_code;
    logic              n_out_last;
    logic              n_pend_vld;
    logic [CODE_W-1:0] n_pend_code;
    t_page             n_page;

    logic acc;
    logic need_ltr;
    logic need_fig;

    assign o_rdy    = !r_out_vld || (o_code.ready && !r_pend_vld);
    assign acc      = i_vld && o_rdy;
    assign need_ltr = i_entry.mapped && i_entry.cls == CLS_LTR && r_page != PAGE_LTR;
    assign need_fig = i_entry.mapped && i_entry.cls == CLS_FIG && r_page != PAGE_FIG;

    always_comb begin
        n_out_vld   = r_out_vld;
        n_out_code  = r_out_code;
        n_out_last  = r_out_last;
        n_pend_vld  = r_pend_vld;
        n_pend_code = r_pend_code;
        n_page      = r_page;
        if (r_out_vld && o_code.ready) begin
            if (r_pend_vld) begin
                n_out_code = r_pend_code;
                n_out_last = 1'b1;
                n_pend_vld = 1'b0;
            end else begin
                n_out_vld = 1'b0;
            end
        end
        if (acc && i_entry.mapped) begin
            n_out_vld = 1'b1;
            if (need_fig) begin
                n_out_code  = CODE_FIGS;
                n_out_last  = 1'b0;
                n_pend_vld  = 1'b1;
                n_pend_code = i_entry.code;
                n_page      = PAGE_FIG;
            end else if (need_ltr) begin
                n_out_code  = CODE_LTRS;
                n_out_last  = 1'b0;
                n_pend_vld  = 1'b1;
                n_pend_code = i_entry.code;
                n_page      = PAGE_LTR;
            end else begin
                n_out_code = i_entry.code;
                n_out_last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_page     <= PAGE_UNK;
        end else begin
            r_out_vld  <= n_out_vld;
            r_pend_vld <= n_pend_vld;
            r_page     <= n_page;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_code  <= n_out_code;
        r_out_last  <= n_out_last;
        r_pend_code <= n_pend_code;
    end

    assign o_code.valid     = r_out_vld;
    assign o_code.ita2_code = r_out_code;
    assign o_code.last      = r_out_last;

`ifndef SYNTHESIS
    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> r_out_vld && !r_out_last)
        else $error("pending code without a shift code in front");
    a_shift_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out_last |-> r_out_code == CODE_FIGS || r_out_code == CODE_LTRS)
        else $error("non-final code is not a shift code");
    a_fig_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_entry.mapped && i_entry.cls == CLS_FIG |=> r_page == PAGE_FIG)
        else $error("figures item left shift page wrong");
    a_ltr_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_entry.mapped && i_entry.cls == CLS_LTR |=> r_page == PAGE_LTR)
        else $error("letters item left shift page wrong");
`endif

endmodule

### hw/rtl/ita2_shift_encoder.sv
// ITA2 shift encoder: Latin-1 character in, ITA2 codes out.
// Built from ita2e_lookup and ita2e_shift; depends on ita2e_pkg and ita2e_ifs.
//
// Usage:
//   i_char carries one 8-bit character per item; o_code carries 5-bit ITA2
//   codes, with last set on the final code of each character. Both channels
//   are valid/ready; an item moves on a clock edge with valid and ready high.
//   A letters or figures character whose class differs from the current shift
//   is preceded by LTRS (31) or FIGS (27) with last low. Carriage return, line
//   feed and space come out alone. Unmapped characters give no output.
//   Input accept and the first code being offered are separated by the lookup
//   input register and the shift result register. Throughput: one character per
//   cycle while the receiver is ready; a character needing a shift code holds the
//   output for both its codes (one result register plus one pending-code slot).
//   Reset (synchronous, active low) empties both stages and sets the shift to
//   unknown, so the first letters or figures character always gets a shift code.
//   When the receiver stalls, the output holds its code, the pipeline fills and
//   i_char.ready drops after one more character is buffered.
module ita2_shift_encoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ita2e_char_if.sink    i_char,
    ita2e_code_if.source  o_code
);
    import ita2e_pkg::*;

    logic   lk_vld;
    logic   sh_rdy;
    t_entry lk_entry;

    ita2e_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .o_vld   (lk_vld),
        .i_rdy   (sh_rdy),
        .o_entry (lk_entry)
    );

    ita2e_shift u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (lk_vld),
        .o_rdy   (sh_rdy),
        .i_entry (lk_entry),
        .o_code  (o_code)
    );

endmodule
